[src/bmp24_stream_parser_macros.svh]
// Assertion macros used by the checker file of the BMP24 stream parser.
// Each macro expects clk and rst_n in scope.
`ifndef BMP24_STREAM_PARSER_MACROS_SVH
`define BMP24_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define BMP24SP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp24sp assertion failed");

// Next-cycle implication, ignored while reset is active.
`define BMP24SP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp24sp assertion failed");

`endif

[src/bmp24sp_pkg.sv]
// Shared types and constants of the BMP24 stream parser.
// No dependencies.
package bmp24sp_pkg;

  localparam int HDR_BYTES = 54;
  localparam int HDR_KEPT  = 34;

  localparam logic [15:0] BMP_SIG   = 16'h4D42;
  localparam logic [31:0] INFO_SIZE = 32'd40;
  localparam logic [15:0] BMP_BPP   = 16'd24;
  localparam logic [15:0] BMP_PLANE = 16'd1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_SIG    = 3'd2,
    ST_BITS   = 3'd3,
    ST_HDR    = 3'd4,
    ST_TRUNC  = 3'd5,
    ST_BIG    = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  pixel_byte0;
    logic [7:0]  pixel_byte1;
    logic [7:0]  pixel_byte2;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic [2:0]  status_code;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last_result;
  } out_item_t;

  // Results produced by one item: cnt is 0, 1 or 2, r0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  // Decoded header fields and verdict.
  typedef struct packed {
    status_t     code;
    logic [31:0] width;
    logic [31:0] height_abs;
    logic        top_down;
    logic [31:0] offset;
  } hdr_info_t;

endpackage

[src/bmp24sp_hdr_check.sv]
// Header decode and validity check of the BMP24 stream parser.
// Depends on bmp24sp_pkg.
module bmp24sp_hdr_check #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic [bmp24sp_pkg::HDR_KEPT-1:0][7:0] hdr_bytes,
  output bmp24sp_pkg::hdr_info_t                info
);

  localparam logic [31:0] MAXW = 32'(MAX_WIDTH);
  localparam logic [31:0] MAXH = 32'(MAX_HEIGHT);

  logic [15:0] sig, bpp, planes;
  logic [31:0] offset, info_sz, width, height, compr, habs;

  assign sig     = {hdr_bytes[1],  hdr_bytes[0]};
  assign offset  = {hdr_bytes[13], hdr_bytes[12], hdr_bytes[11], hdr_bytes[10]};
  assign info_sz = {hdr_bytes[17], hdr_bytes[16], hdr_bytes[15], hdr_bytes[14]};
  assign width   = {hdr_bytes[21], hdr_bytes[20], hdr_bytes[19], hdr_bytes[18]};
  assign height  = {hdr_bytes[25], hdr_bytes[24], hdr_bytes[23], hdr_bytes[22]};
  assign planes  = {hdr_bytes[27], hdr_bytes[26]};
  assign bpp     = {hdr_bytes[29], hdr_bytes[28]};
  assign compr   = {hdr_bytes[33], hdr_bytes[32], hdr_bytes[31], hdr_bytes[30]};

  // negative height means top-down storage
  assign habs = height[31] ? (32'd0 - height) : height;

  always_comb begin
    info.width      = width;
    info.height_abs = habs;
    info.top_down   = height[31];
    info.offset     = offset;
    if (sig != bmp24sp_pkg::BMP_SIG) begin
      info.code = bmp24sp_pkg::ST_SIG;
    end else if (bpp != bmp24sp_pkg::BMP_BPP) begin
      info.code = bmp24sp_pkg::ST_BITS;
    end else if (info_sz != bmp24sp_pkg::INFO_SIZE || planes != bmp24sp_pkg::BMP_PLANE ||
                 compr != 32'd0 || width == 32'd0 || width[31] || height == 32'd0 ||
                 offset < 32'(bmp24sp_pkg::HDR_BYTES)) begin
      info.code = bmp24sp_pkg::ST_HDR;
    end else if (width > MAXW || habs > MAXH) begin
      info.code = bmp24sp_pkg::ST_BIG;
    end else begin
      info.code = bmp24sp_pkg::ST_OK;
    end
  end

endmodule

[src/bmp24sp_core.sv]
// Parse state machine of the BMP24 stream parser: header capture, skip,
// pixel assembly and status. Depends on bmp24sp_pkg and bmp24sp_hdr_check.
module bmp24sp_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  bmp24sp_pkg::in_item_t item,
  output bmp24sp_pkg::push_t    push
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SKIP    = 5'b00010,
    PH_PIXEL   = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_TAILPAD = 5'b10000
  } phase_t;

  phase_t                                phase_r, phase_nxt;
  logic [5:0]                            hcnt_r, hcnt_nxt;
  logic [bmp24sp_pkg::HDR_KEPT-1:0][7:0] hstore_r;
  logic [31:0]                           skip_r, skip_nxt;
  logic [WW-1:0]                         col_r, col_nxt;
  logic [HW-1:0]                         row_r, row_nxt;
  logic [1:0]                            bip_r, bip_nxt;
  logic [15:0]                           held_r, held_nxt;
  logic [1:0]                            pad_r, pad_nxt;
  logic [WW-1:0]                         w_r, w_nxt;
  logic [HW-1:0]                         habs_r, habs_nxt;
  logic                                  tdown_r, tdown_nxt;
  logic                                  hstore_we;
  logic [HW-1:0]                         tgt_row;
  logic [1:0]                            w_pad;
  bmp24sp_pkg::hdr_info_t                hinfo;
  bmp24sp_pkg::out_item_t                pix;

  bmp24sp_hdr_check #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_hdr_check (
    .hdr_bytes(hstore_r),
    .info     (hinfo)
  );

  function automatic bmp24sp_pkg::out_item_t mk_status(
    bmp24sp_pkg::status_t code, logic dims, logic [12:0] w13, logic [12:0] h13);
    bmp24sp_pkg::out_item_t r;
    r              = '0;
    r.result_kind  = bmp24sp_pkg::KIND_STATUS;
    r.status_code  = code;
    r.image_width  = dims ? w13 : 13'd0;
    r.image_height = dims ? h13 : 13'd0;
    r.last_result  = 1'b1;
    return r;
  endfunction

  logic [12:0] w13, h13;
  logic [31:0] w32, col32, row32, h32;
  assign w32   = 32'(w_r);
  assign h32   = 32'(habs_r);
  assign w13   = w32[12:0];
  assign h13   = h32[12:0];
  assign w_pad = w32[1:0];

  assign tgt_row = tdown_r ? row_r : (habs_r - HW'(1) - row_r);
  assign col32   = 32'(col_r);
  assign row32   = 32'(tgt_row);

  always_comb begin
    pix              = '0;
    pix.result_kind  = bmp24sp_pkg::KIND_PIXEL;
    pix.pixel_byte0  = held_r[7:0];
    pix.pixel_byte1  = held_r[15:8];
    pix.pixel_byte2  = item.data_byte;
    pix.pixel_column = col32[11:0];
    pix.pixel_row    = row32[11:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    skip_nxt  = skip_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    bip_nxt   = bip_r;
    held_nxt  = held_r;
    pad_nxt   = pad_r;
    w_nxt     = w_r;
    habs_nxt  = habs_r;
    tdown_nxt = tdown_r;
    hstore_we = 1'b0;
    push      = '0;

    if (fire) begin
      if (item.stream_end) begin
        if (phase_r == PH_HEADER) begin
          push.cnt = 2'd1;
          push.r0  = mk_status(bmp24sp_pkg::ST_SHORT, 1'b0, w13, h13);
        end else if (phase_r != PH_DONE) begin
          push.cnt = 2'd1;
          push.r0  = mk_status(bmp24sp_pkg::ST_TRUNC, 1'b1, w13, h13);
        end
        phase_nxt = PH_HEADER;
        hcnt_nxt  = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            hstore_we = (hcnt_r < 6'(bmp24sp_pkg::HDR_KEPT));
            if (hcnt_r == 6'(bmp24sp_pkg::HDR_BYTES - 1)) begin
              hcnt_nxt = '0;
              if (hinfo.code != bmp24sp_pkg::ST_OK) begin
                push.cnt  = 2'd1;
                push.r0   = mk_status(hinfo.code, 1'b0, w13, h13);
                phase_nxt = PH_DONE;
              end else begin
                w_nxt     = hinfo.width[WW-1:0];
                habs_nxt  = hinfo.height_abs[HW-1:0];
                tdown_nxt = hinfo.top_down;
                col_nxt   = '0;
                row_nxt   = '0;
                bip_nxt   = '0;
                held_nxt  = '0;
                pad_nxt   = '0;
                skip_nxt  = hinfo.offset - 32'(bmp24sp_pkg::HDR_BYTES);
                phase_nxt = (skip_nxt != 32'd0) ? PH_SKIP : PH_PIXEL;
              end
            end else begin
              hcnt_nxt = hcnt_r + 6'd1;
            end
          end
          PH_SKIP: begin
            skip_nxt = skip_r - 32'd1;
            if (skip_r == 32'd1) begin
              phase_nxt = PH_PIXEL;
            end
          end
          PH_PIXEL: begin
            if (pad_r != 2'd0) begin
              pad_nxt = pad_r - 2'd1;
            end else begin
              case (bip_r)
                2'd0: begin
                  held_nxt = {8'd0, item.data_byte};
                  bip_nxt  = 2'd1;
                end
                2'd1: begin
                  held_nxt = {item.data_byte, held_r[7:0]};
                  bip_nxt  = 2'd2;
                end
                default: begin
                  bip_nxt  = 2'd0;
                  push.cnt = 2'd1;
                  push.r0  = pix;
                  if (col_r != w_r - WW'(1)) begin
                    col_nxt = col_r + WW'(1);
                  end else begin
                    col_nxt = '0;
                    pad_nxt = w_pad;
                    if (row_r != habs_r - HW'(1)) begin
                      row_nxt = row_r + HW'(1);
                    end else if (w_pad != 2'd0) begin
                      phase_nxt = PH_TAILPAD;
                    end else begin
                      push.cnt  = 2'd2;
                      push.r1   = mk_status(bmp24sp_pkg::ST_OK, 1'b1, w13, h13);
                      phase_nxt = PH_DONE;
                    end
                  end
                end
              endcase
            end
          end
          PH_TAILPAD: begin
            pad_nxt = pad_r - 2'd1;
            if (pad_r == 2'd1) begin
              push.cnt  = 2'd1;
              push.r0   = mk_status(bmp24sp_pkg::ST_OK, 1'b1, w13, h13);
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            // done: bytes are dropped until the stream ends
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      skip_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= '0;
      held_r  <= '0;
      pad_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      skip_r  <= skip_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      bip_r   <= bip_nxt;
      held_r  <= held_nxt;
      pad_r   <= pad_nxt;
    end
  end

  // header bytes and decoded geometry: written before use, no reset
  always_ff @(posedge clk) begin
    if (hstore_we) begin
      hstore_r[hcnt_r] <= item.data_byte;
    end
    w_r     <= w_nxt;
    habs_r  <= habs_nxt;
    tdown_r <= tdown_nxt;
  end

endmodule

[src/bmp24sp_outq.sv]
// Four-entry result queue of the BMP24 stream parser; takes up to two
// results per cycle, delivers one while out_stall is low. Depends on bmp24sp_pkg.
module bmp24sp_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bmp24sp_pkg::push_t     push,
  input  logic                   out_stall,
  output logic                   out_valid,
  output bmp24sp_pkg::out_item_t out_data,
  output logic                   room
);

  bmp24sp_pkg::out_item_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // two free slots needed: one item may bring two results
  assign room      = (cnt_r <= 3'd2);

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + 2'd1] <= push.r1;
    end
  end

endmodule

[src/bmp24_stream_parser.sv]
// BMP24 stream parser, top level: input register, parse core, result queue.
// Depends on bmp24sp_pkg, bmp24sp_core, bmp24sp_outq.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one request per file byte;
//    a request with stream_end set marks the end of the file, carries no byte.
//  - Result channel (out_valid/out_stall/out_data): pixel results (column,
//    target row, three pixel bytes) and one final status per file, which
//    carries last_result. Width/height are reported with ok and truncated.
//  - An accepted request is held in the input register; its results go
//    into the result queue. Throughput: one request per cycle while
//    in_stall is low; the parse logic handles every byte in a single pass.
//  - The final pixel and the ok status can come from one byte; the result
//    queue holds four entries and takes a byte only with two free slots.
//  - When out_stall is held the queue fills and in_stall rises; no result
//    is lost or repeated.
//  - Reset (rst_n low, synchronous) returns to header capture with empty
//    queue; after a final status, bytes are dropped until stream_end.
module bmp24_stream_parser #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bmp24sp_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output bmp24sp_pkg::out_item_t out_data
);

  // input register
  logic                  s_valid_r, s_valid_nxt;
  bmp24sp_pkg::in_item_t s_item_r;
  logic                  room;
  logic                  fire;
  bmp24sp_pkg::push_t    push;

  // the held request moves into the core when the queue has room
  assign fire        = s_valid_r && room;
  assign in_stall    = s_valid_r && !room;
  assign s_valid_nxt = in_stall ? s_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item_r <= in_data;
    end
  end

  bmp24sp_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (s_item_r),
    .push (push)
  );

  bmp24sp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .room     (room)
  );

endmodule

[src/bmp24sp_checker.sv]
// Port-level checks of the BMP24 stream parser and their bind.
// Depends on bmp24sp_pkg and bmp24_stream_parser_macros.svh.
`include "bmp24_stream_parser_macros.svh"

module bmp24sp_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input bmp24sp_pkg::in_item_t  in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input bmp24sp_pkg::out_item_t out_data
);

  `BMP24SP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `BMP24SP_ASSERT_NOW(a_kind_last, out_valid, out_data.result_kind == out_data.last_result)
  `BMP24SP_ASSERT_NOW(a_pixel_clean, out_valid && !out_data.result_kind, out_data.status_code == bmp24sp_pkg::ST_OK && out_data.image_width == 13'd0 && out_data.image_height == 13'd0)
  `BMP24SP_ASSERT_NOW(a_status_clean, out_valid && out_data.result_kind, out_data.status_code <= bmp24sp_pkg::ST_BIG && out_data.pixel_column == 12'd0 && out_data.pixel_row == 12'd0 && out_data.pixel_byte2 == 8'd0)
  `BMP24SP_ASSERT_NOW(a_dims_only, out_valid && out_data.result_kind && out_data.status_code != bmp24sp_pkg::ST_OK && out_data.status_code != bmp24sp_pkg::ST_TRUNC, out_data.image_width == 13'd0 && out_data.image_height == 13'd0)

endmodule

bind bmp24_stream_parser bmp24sp_checker u_bmp24sp_checker (.*);
